>>> src/fsl_pkg.sv
// Shared types and constants for the flash sector locator.
// Holds the banked sector maps, register indexes, status codes and the pipeline stage record.
// No dependencies.
package fsl_pkg;

    localparam int N_TWELVE = 12;
    localparam int N_EIGHT  = 8;

    // Sector sizes and cumulative end offsets within a 1 MB bank, in KB.
    typedef logic [10:0] kb_t;

    localparam kb_t SEC_TWELVE_KB [N_TWELVE] =
        '{11'd16, 11'd16, 11'd16, 11'd16, 11'd64, 11'd128,
          11'd128, 11'd128, 11'd128, 11'd128, 11'd128, 11'd128};
    localparam kb_t END_TWELVE_KB [N_TWELVE] =
        '{11'd16, 11'd32, 11'd48, 11'd64, 11'd128, 11'd256,
          11'd384, 11'd512, 11'd640, 11'd768, 11'd896, 11'd1024};

    localparam kb_t SEC_EIGHT_KB [N_EIGHT] =
        '{11'd32, 11'd32, 11'd32, 11'd32, 11'd128, 11'd256, 11'd256, 11'd256};
    localparam kb_t END_EIGHT_KB [N_EIGHT] =
        '{11'd32, 11'd64, 11'd96, 11'd128, 11'd256, 11'd512, 11'd768, 11'd1024};

    // Configuration register indexes.
    typedef logic [2:0] cfg_idx_t;
    localparam cfg_idx_t REG_BASE_ADDR   = 3'd0;
    localparam cfg_idx_t REG_FLASH_BYTES = 3'd1;
    localparam cfg_idx_t REG_PAGE_BYTES  = 3'd2;
    localparam cfg_idx_t REG_LAYOUT      = 3'd3;

    // Layout codes; the unused code behaves as uniform.
    typedef logic [1:0] mode_t;
    localparam mode_t MODE_UNIFORM = 2'd0;
    localparam mode_t MODE_TWELVE  = 2'd1;
    localparam mode_t MODE_EIGHT   = 2'd2;

    // Result status codes.
    typedef logic [1:0] status_t;
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_OUTSIDE   = 2'd1;
    localparam status_t ST_PAGE_ZERO = 2'd2;

    // Record carried from stage to stage.
    typedef struct packed {
        logic [31:0] off;     // address minus flash base
        logic [31:0] rem;     // partial remainder of off by page size
        logic        lt;      // address below flash base
        logic        oor;     // address outside flash
        logic        banked;  // sector found in a banked map
        logic [31:0] bofs;    // sector offset from flash base
        logic [18:0] blen;    // banked sector length in bytes
    } stage_t;

endpackage

>>> src/flash_sector_locator_core.sv
// Flash erase-sector locator: top level with the full lookup pipeline.
// Depends on fsl_pkg for the sector maps, codes and the stage record.
//
// The block accepts one address per clock cycle unless the output side stalls.
// Each result passes through one capture stage, one range and bank-map stage,
// a 32-stage restoring divider that settles one quotient bit per stage for the
// uniform page rounding, one offset-select stage and the output register.
// Each stage holds its item until the next stage has room, so
// stalls on the output side back up without loss. Configuration writes are taken
// in any cycle (cfg_ready is always high) and must only be made while no query is
// in flight.
module flash_sector_locator_core
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // Query input.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] query_addr
    // Result output.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [1:0] status, [33:2] sector_start,
                                   // [65:34] sector_len, [71:66] zero
);

    localparam int NSTG      = 35;
    localparam int DIV_FIRST = 2;
    localparam int DIV_LAST  = 33;
    localparam int SEL_STG   = 34;

    logic [31:0] base_reg;
    logic [31:0] size_reg;
    logic [31:0] page_reg;
    logic [1:0]  mode_reg;

    fsl_pkg::stage_t st_reg  [NSTG];
    fsl_pkg::stage_t st_next [NSTG];
    logic            vld_reg [NSTG];
    logic            rdy     [NSTG];

    logic        out_vld_reg;
    logic [1:0]  out_status_reg;
    logic [31:0] out_start_reg;
    logic [31:0] out_len_reg;
    logic [1:0]  out_status_next;
    logic [31:0] out_start_next;
    logic [31:0] out_len_next;
    logic        out_rdy;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= 32'h0800_0000;
            size_reg <= 32'h0010_0000;
            page_reg <= 32'd2048;
            mode_reg <= fsl_pkg::MODE_UNIFORM;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                fsl_pkg::REG_BASE_ADDR:   base_reg <= cfg_data;
                fsl_pkg::REG_FLASH_BYTES: size_reg <= cfg_data;
                fsl_pkg::REG_PAGE_BYTES:  page_reg <= cfg_data;
                fsl_pkg::REG_LAYOUT:      mode_reg <= cfg_data[1:0];
                default:                  ;
            endcase
        end
    end

    // Stage readiness: a stage can load when it is empty or its contents move on.
    assign out_rdy = !out_vld_reg || m_tready;

    always_comb
    begin
        rdy[NSTG-1] = !vld_reg[NSTG-1] || out_rdy;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign s_tready = rdy[0];

    // Stage logic.
    always_comb
    begin
        logic [9:0]  inb_kb;
        logic [32:0] trial;
        logic [4:0]  bit_idx;
        logic        hit;
        logic [10:0] acc_kb;
        logic [10:0] sz_kb;

        inb_kb  = 10'd0;
        trial   = 33'd0;
        bit_idx = 5'd0;
        hit     = 1'b0;
        acc_kb  = 11'd0;
        sz_kb   = 11'd0;

        // Capture: offset from the flash base and the below-base flag.
        st_next[0]        = '0;
        st_next[0].off    = s_tdata[31:0] - base_reg;
        st_next[0].lt     = s_tdata[31:0] < base_reg;

        // Range check and bank-map search. The maps cover a whole bank, so
        // a banked layout always finds a sector.
        st_next[1]        = st_reg[0];
        st_next[1].oor    = st_reg[0].lt || (st_reg[0].off >= size_reg);
        st_next[1].rem    = 32'd0;
        inb_kb            = st_reg[0].off[19:10];
        if (mode_reg == fsl_pkg::MODE_TWELVE)
        begin
            for (int k = fsl_pkg::N_TWELVE - 1; k >= 0; k--)
            begin
                if ({1'b0, inb_kb} < fsl_pkg::END_TWELVE_KB[k])
                begin
                    hit    = 1'b1;
                    sz_kb  = fsl_pkg::SEC_TWELVE_KB[k];
                    acc_kb = fsl_pkg::END_TWELVE_KB[k] - fsl_pkg::SEC_TWELVE_KB[k];
                end
            end
        end
        else if (mode_reg == fsl_pkg::MODE_EIGHT)
        begin
            for (int k = fsl_pkg::N_EIGHT - 1; k >= 0; k--)
            begin
                if ({1'b0, inb_kb} < fsl_pkg::END_EIGHT_KB[k])
                begin
                    hit    = 1'b1;
                    sz_kb  = fsl_pkg::SEC_EIGHT_KB[k];
                    acc_kb = fsl_pkg::END_EIGHT_KB[k] - fsl_pkg::SEC_EIGHT_KB[k];
                end
            end
        end
        st_next[1].banked = hit;
        st_next[1].bofs   = {st_reg[0].off[31:20], acc_kb[9:0], 10'd0};
        st_next[1].blen   = {sz_kb[8:0], 10'd0};

        // Restoring division: one quotient bit per stage, most significant first.
        for (int i = DIV_FIRST; i <= DIV_LAST; i++)
        begin
            st_next[i] = st_reg[i-1];
            bit_idx    = 5'(DIV_LAST - i);
            trial      = {st_reg[i-1].rem, st_reg[i-1].off[bit_idx]};
            if (trial >= {1'b0, page_reg})
            begin
                st_next[i].rem = 32'(trial - {1'b0, page_reg});
            end
            else
            begin
                st_next[i].rem = trial[31:0];
            end
        end

        // Offset of the sector from the flash base.
        st_next[SEL_STG] = st_reg[SEL_STG-1];
        if (!st_reg[SEL_STG-1].banked)
        begin
            st_next[SEL_STG].bofs = st_reg[SEL_STG-1].off - st_reg[SEL_STG-1].rem;
        end
    end

    // Result formation.
    always_comb
    begin
        out_status_next = fsl_pkg::ST_OK;
        out_start_next  = base_reg + st_reg[NSTG-1].bofs;
        out_len_next    = st_reg[NSTG-1].banked ? {13'd0, st_reg[NSTG-1].blen} : page_reg;
        if (st_reg[NSTG-1].oor)
        begin
            out_status_next = fsl_pkg::ST_OUTSIDE;
            out_start_next  = 32'd0;
            out_len_next    = 32'd0;
        end
        else if (!st_reg[NSTG-1].banked && page_reg == 32'd0)
        begin
            out_status_next = fsl_pkg::ST_PAGE_ZERO;
            out_start_next  = 32'd0;
            out_len_next    = 32'd0;
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSTG; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
            if (out_rdy)
            begin
                out_vld_reg <= vld_reg[NSTG-1];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NSTG; i++)
        begin
            if (rdy[i])
            begin
                st_reg[i] <= st_next[i];
            end
        end
        if (out_rdy)
        begin
            out_status_reg <= out_status_next;
            out_start_reg  <= out_start_next;
            out_len_reg    <= out_len_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0, out_len_reg, out_start_reg, out_status_reg};

endmodule

>>> tb/sv/sector_lookup_checker.sv
// Scoreboard for the flash sector locator: keeps its own copy of the registers,
// predicts the sector for every accepted address and checks the results in order.
// Depends on fsl_pkg for the register indexes, layout codes and status codes.
module sector_lookup_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    output int          fail_count,
    output int          result_count,
    output int          expected_left,
    output int          resolved_count,
    output int          outside_count,
    output int          zero_page_count
);

    typedef struct packed {
        fsl_pkg::status_t status;
        logic [31:0]      start;
        logic [31:0]      len;
    } sector_t;

    logic [31:0]    base_addr;
    logic [31:0]    flash_bytes;
    logic [31:0]    page_bytes;
    fsl_pkg::mode_t layout;

    sector_t expected_sectors[$];

    // Sector sizes in bytes; the eight-sector map is the first eight sectors of the twelve-sector one doubled.
    function automatic logic [31:0] sector_bytes(input fsl_pkg::mode_t mode, input int idx);
        logic [31:0] kb;
        if (idx < 4)
            kb = 16;
        else if (idx == 4)
            kb = 64;
        else
            kb = 128;
        if (mode == fsl_pkg::MODE_EIGHT)
            kb = kb * 2;
        return kb * 1024;
    endfunction

    function automatic sector_t locate_sector(input logic [31:0] addr);
        sector_t     r;
        logic [31:0] off;
        logic [31:0] bank;
        logic [31:0] inb;
        logic [31:0] acc;
        logic [31:0] sz;
        int          count;
        bit          hit;
        r   = '0;
        hit = 1'b0;
        off = addr - base_addr;
        if (addr < base_addr || off >= flash_bytes)
        begin
            r.status = fsl_pkg::ST_OUTSIDE;
        end
        else
        begin
            if (layout == fsl_pkg::MODE_TWELVE || layout == fsl_pkg::MODE_EIGHT)
            begin
                bank  = {off[31:20], 20'd0};
                inb   = {12'd0, off[19:0]};
                acc   = '0;
                count = (layout == fsl_pkg::MODE_TWELVE) ? 12 : 8;
                for (int i = 0; i < count; i++)
                begin
                    sz = sector_bytes(layout, i);
                    if (!hit && inb < acc + sz)
                    begin
                        r.status = fsl_pkg::ST_OK;
                        r.start  = base_addr + bank + acc;
                        r.len    = sz;
                        hit      = 1'b1;
                    end
                    acc = acc + sz;
                end
            end
            // Uniform pages, which the unused layout code also selects.
            if (!hit)
            begin
                if (page_bytes == 0)
                begin
                    r.status = fsl_pkg::ST_PAGE_ZERO;
                end
                else
                begin
                    r.status = fsl_pkg::ST_OK;
                    r.start  = base_addr + (off - off % page_bytes);
                    r.len    = page_bytes;
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sector_t want;
        sector_t got;
        if (!rst_n)
        begin
            base_addr       = 32'h0800_0000;
            flash_bytes     = 32'h0010_0000;
            page_bytes      = 32'd2048;
            layout          = fsl_pkg::MODE_UNIFORM;
            expected_sectors.delete();
            fail_count      = 0;
            result_count    = 0;
            expected_left   = 0;
            resolved_count  = 0;
            outside_count   = 0;
            zero_page_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    fsl_pkg::REG_BASE_ADDR:   base_addr   = cfg_data;
                    fsl_pkg::REG_FLASH_BYTES: flash_bytes = cfg_data;
                    fsl_pkg::REG_PAGE_BYTES:  page_bytes  = cfg_data;
                    fsl_pkg::REG_LAYOUT:      layout      = fsl_pkg::mode_t'(cfg_data[1:0]);
                    default:                  ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_sectors.push_back(locate_sector(s_tdata));
            if (m_tvalid && m_tready)
            begin
                got.status = fsl_pkg::status_t'(m_tdata[1:0]);
                got.start  = m_tdata[33:2];
                got.len    = m_tdata[65:34];
                result_count++;
                case (got.status)
                    fsl_pkg::ST_OK:        resolved_count++;
                    fsl_pkg::ST_OUTSIDE:   outside_count++;
                    fsl_pkg::ST_PAGE_ZERO: zero_page_count++;
                    default:               ;
                endcase
                if (expected_sectors.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("Unexpected result %0d at %0t: status %0d start %h len %h",
                                 result_count, $time, got.status, got.start, got.len);
                end
                else
                begin
                    want = expected_sectors.pop_front();
                    if (got.status !== want.status || got.start !== want.start ||
                        got.len !== want.len)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("Mismatch %0d at %0t: expected %0d %h %h, got %0d %h %h",
                                     result_count, $time, want.status, want.start, want.len,
                                     got.status, got.start, got.len);
                    end
                end
            end
            expected_left = expected_sectors.size();
        end
    end

endmodule

>>> tb/sv/tb_top.sv
// Top of the flash sector locator testbench: clock, reset, register programming,
// address stimulus with random gaps and output stalls, watchdog and verdict.
// Depends on fsl_pkg, flash_sector_locator_core and sector_lookup_checker.
module tb_top;

    localparam int                CLK_HALF        = 6;
    localparam int                RESET_CYCLES    = 9;
    localparam int                IDLE_LIMIT      = 2000;
    localparam int                HOLD_CYCLES     = 300;
    localparam int                DRAIN_CYCLES    = 40;
    localparam int                RANDOM_PHASES   = 16;
    localparam int                ITEMS_PER_PHASE = 52;
    localparam int                PRESSURE_PHASE  = 2;
    localparam fsl_pkg::cfg_idx_t REG_SPARE       = 3'd6;
    localparam fsl_pkg::mode_t    MODE_SPARE      = 2'd3;

    typedef struct packed {
        fsl_pkg::cfg_idx_t idx;
        logic [31:0]       data;
    } reg_write_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;   // [31:0] query_addr
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [71:0] m_tdata;          // [1:0] status, [33:2] sector_start, [65:34] sector_len

    int fail_count;
    int result_count;
    int expected_left;
    int resolved_count;
    int outside_count;
    int zero_page_count;
    int sent_count     = 0;
    int settings_count = 0;
    int idle_cycles    = 0;
    bit tx_burst       = 1'b0;
    bit rx_burst       = 1'b0;
    bit hold_request   = 1'b0;

    reg_write_t reg_writes[$];

    flash_sector_locator_core i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    sector_lookup_checker i_sector_check
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .result_count    (result_count),
        .expected_left   (expected_left),
        .resolved_count  (resolved_count),
        .outside_count   (outside_count),
        .zero_page_count (zero_page_count)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_LIMIT - 1)
            begin
                $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Result side: random stalls, quiet stretches, and one long hold-off on request.
    initial
    begin
        int stall;
        wait (rst_n);
        forever
        begin
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 40) == 0)
                    rx_burst = !rx_burst;
                stall = rx_burst ? 0 : $urandom_range(0, 10);
                if (stall > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Leaves s_tvalid high so that back-to-back transactions need no extra edge.
    task automatic send_addr(input logic [31:0] addr);
        int gap;
        if ($urandom_range(0, 40) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= addr;
        do @(posedge clk); while (!s_tready);
        sent_count++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (result_count < sent_count) @(posedge clk);
    endtask

    task automatic program_regs();
        reg_write_t w;
        drain();
        while (reg_writes.size() > 0)
        begin
            w = reg_writes.pop_front();
            cfg_valid <= 1'b1;
            cfg_index <= w.idx;
            cfg_data  <= w.data;
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        settings_count++;
    endtask

    task automatic set_layout(input logic [31:0] base, input logic [31:0] size,
                              input logic [31:0] page, input logic [31:0] mode_word);
        reg_writes.push_back(reg_write_t'{fsl_pkg::REG_BASE_ADDR, base});
        reg_writes.push_back(reg_write_t'{fsl_pkg::REG_FLASH_BYTES, size});
        reg_writes.push_back(reg_write_t'{fsl_pkg::REG_PAGE_BYTES, page});
        reg_writes.push_back(reg_write_t'{fsl_pkg::REG_LAYOUT, mode_word});
        program_regs();
    endtask

    initial
    begin
        logic [31:0]    base;
        logic [31:0]    size;
        logic [31:0]    page;
        logic [31:0]    off;
        fsl_pkg::mode_t mode;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: both range edges, address extremes and page rounding.
        send_addr(32'h0800_0000);
        send_addr(32'h07FF_FFFF);
        send_addr(32'h080F_FFFF);
        send_addr(32'h0810_0000);
        send_addr(32'h0000_0000);
        send_addr(32'hFFFF_FFFF);
        send_addr(32'h0800_0801);

        // Twelve-sector map over two banks; junk above the mode bits, page size ignored.
        set_layout(32'h0800_0000, 32'h0020_0000, 32'h0, 32'hFFFF_FFFD);
        send_addr(32'h0800_3FFF);
        send_addr(32'h0800_4000);
        send_addr(32'h0801_0000);
        send_addr(32'h080F_FFFF);
        send_addr(32'h0810_5000);

        set_layout(32'h0, 32'hFFFF_FFFF, 32'd2048, {30'd0, fsl_pkg::MODE_EIGHT});
        send_addr(32'h0000_7FFF);
        send_addr(32'h0000_8000);
        send_addr(32'h0002_0000);
        send_addr(32'h0004_0000);
        send_addr(32'hFFFF_FFFE);
        send_addr(32'hFFFF_FFFF);

        set_layout(32'hFFFF_F000, 32'h0000_5000, 32'h0, {30'd0, fsl_pkg::MODE_UNIFORM});
        send_addr(32'hFFFF_F800);

        // The unused layout code rounds to pages like the uniform layout.
        set_layout(32'h0000_1000, 32'hFFFF_FFFF, 32'h300, {30'd0, MODE_SPARE});
        send_addr(32'h0000_2234);
        send_addr(32'hFFFF_FFFF);

        set_layout(32'h0, 32'h0, 32'h10, {30'd0, fsl_pkg::MODE_TWELVE});
        send_addr(32'h0000_0000);

        // The last sector runs past the end of flash; a write to a spare index
        // must leave the registers alone.
        set_layout(32'h0, 32'h0000_5000, 32'h0, {30'd0, fsl_pkg::MODE_TWELVE});
        reg_writes.push_back(reg_write_t'{REG_SPARE, 32'hFFFF_FFFF});
        program_regs();
        send_addr(32'h0000_4800);

        set_layout(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, {30'd0, fsl_pkg::MODE_UNIFORM});
        send_addr(32'hFFFF_FFFF);
        send_addr(32'h7FFF_FFFF);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case ($urandom_range(0, 5))
                0:       base = 32'h0;
                1:       base = 32'h0800_0000;
                2:       base = $urandom;
                3:       base = $urandom & 32'hFFF0_0000;
                4:       base = 32'hFFFF_FFFF - $urandom_range(0, 32'h003F_FFFF);
                default: base = $urandom & 32'h7FFF_F000;
            endcase
            case ($urandom_range(0, 7))
                0:       size = 32'h0;
                1:       size = 32'hFFFF_FFFF;
                2:       size = $urandom_range(1, 8) << 20;
                3:       size = $urandom;
                default: size = $urandom_range(1, 32'h0040_0000);
            endcase
            case ($urandom_range(0, 7))
                0:       page = 32'h0;
                1:       page = 32'h1;
                2:       page = 32'hFFFF_FFFF;
                3:       page = 32'h1 << $urandom_range(0, 16);
                4:       page = $urandom;
                default: page = $urandom_range(2, 100000);
            endcase
            mode = fsl_pkg::mode_t'($urandom_range(0, 3));
            set_layout(base, size, page, (32'($urandom) & ~32'h3) | {30'd0, mode});

            // Stop the result side for a long while and keep offering addresses
            // until the pipeline is full and pushes back.
            if (p == PRESSURE_PHASE)
            begin
                hold_request = 1'b1;
                tx_burst     = 1'b1;
            end

            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                off = (size == 0) ? $urandom : $urandom % size;
                case ($urandom_range(0, 9))
                    0:       send_addr($urandom);
                    1:       send_addr(base - $urandom_range(0, 1));
                    2:       send_addr(base + size - $urandom_range(0, 1));
                    3:       send_addr(base + (off & 32'hFFFF_C000) - $urandom_range(0, 1));
                    default: send_addr(base + off);
                endcase
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Summary: %0d lookups checked over %0d register settings, %0d failures.",
                 result_count, settings_count, fail_count);
        $display("Results: %0d resolved, %0d outside flash, %0d with zero page size.",
                 resolved_count, outside_count, zero_page_count);
        if (fail_count == 0 && expected_left == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
